FILE: rtl/montgomery_modular_exponentiation_top_assert.svh
// ----------------------------------------------------------------------------
// Montgomery exponentiation assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef MONTGOMERY_MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MONTGOMERY_MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

// Checked only while out of reset.
`define MME_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Types and constants shared by the Montgomery exponentiation block.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int unsigned OPERAND_BITS_DEF = 32;
  localparam int unsigned FIELD_W          = 32;
  localparam int unsigned EXT_W            = 64;  // widest datapath supported
  localparam int unsigned STATUS_W         = 2;
  localparam logic [FIELD_W-1:0] MODULUS_RST = 32'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BASE_RANGE = 2'd1,
    ST_MOD_EVEN   = 2'd2
  } status_t;

  // Montgomery product kinds: operands and destination follow from the kind.
  typedef enum logic [1:0] {
    MUL_TO_MONT   = 2'd0,  // pm = base * R2
    MUL_Z         = 2'd1,  // zm = zm * pm
    MUL_SQ        = 2'd2,  // pm = pm * pm
    MUL_FROM_MONT = 2'd3   // zm = zm * 1
  } mul_op_t;

  typedef enum logic [3:0] {
    S_CACHE_INIT,
    S_CACHE_R,
    S_SAVE_R,
    S_CACHE_R2,
    S_SAVE_R2,
    S_IDLE,
    S_CHECK,
    S_EXP,
    S_SQ,
    S_MUL,
    S_MUL_FIN,
    S_OUT
  } ctl_state_t;

  typedef struct packed {
    logic    cache_init;
    logic    double_step;
    logic    save_r;
    logic    save_r2;
    logic    clear_cache;
    logic    load_item;
    logic    mul_start;
    logic    mul_step;
    logic    mul_finish;
    mul_op_t mul_op;
    logic    shift_e;
    logic    out_load;
    status_t out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic m_even;
    logic base_ge_m;
    logic e_zero;
    logic e_lsb;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/montgomery_modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// montgomery_modular_exponentiation_top
// base^exponent mod modulus, right-to-left square-and-multiply over a
// bit-serial radix-2 Montgomery multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg_* write channel loads the modulus (always ready). After a write, and
//    after reset (modulus 3), the block derives R mod M and R^2 mod M
//    (R = 2^OPERAND_BITS) with in_ready low.
//    An even modulus skips the derivation.
//  - in_* channel takes one (base, exponent) pair per transfer; one result
//    transfer (power_result, status) comes back on out_* for each one.
//  - Work per item: each Montgomery product runs bit-serially in the
//    shared multiplier. An item costs 2 products for domain entry/exit, one
//    squaring per exponent bit up to the top set bit and one extra product
//    per set bit, then the result is loaded. With 32-bit operands and
//    an all-ones exponent that is 66 products; an error status (even
//    modulus, base not below modulus) skips the products.
//  - One item is in work at a time; the next is taken as soon as the result
//    sits in the output register, even while the receiver stalls it.
//  - A stalled result holds out_valid and its payload until taken; the
//    sequencer waits only if a second result is ready before the first left.
// ----------------------------------------------------------------------------
module montgomery_modular_exponentiation_top import mme_pkg::*; #(
  parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // item input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FIELD_W-1:0]  in_base,
  input  logic [FIELD_W-1:0]  in_exponent,
  // result output
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FIELD_W-1:0]  out_power_result,
  output logic [STATUS_W-1:0] out_status,
  // modulus write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [FIELD_W-1:0]  cfg_modulus
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_wr;

  // modulus register takes a write in any cycle
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  mme_ctrl #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg_wr   (cfg_wr),
    .stat     (stat),
    .cmd      (cmd)
  );

  mme_datapath #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_base          (in_base),
    .in_exponent      (in_exponent),
    .cfg_wr           (cfg_wr),
    .cfg_modulus      (cfg_modulus),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_power_result (out_power_result),
    .out_status       (out_status)
  );

endmodule

FILE: rtl/mme_datapath.sv
// ----------------------------------------------------------------------------
// mme_datapath
// Modulus register, R / R^2 cache, bit-serial Montgomery multiplier,
// exponent shifter and output register.
// ----------------------------------------------------------------------------
module mme_datapath import mme_pkg::*; #(
  parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [FIELD_W-1:0] in_base,
  input  logic [FIELD_W-1:0] in_exponent,
  input  logic               cfg_wr,
  input  logic [FIELD_W-1:0] cfg_modulus,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [FIELD_W-1:0] out_power_result,
  output logic [STATUS_W-1:0] out_status
);

  localparam int unsigned W = OPERAND_BITS;

  logic [FIELD_W-1:0] mod_r;
  logic [EXT_W-1:0]   mod_ext, base_ext, zm_ext;
  logic [W-1:0]       m_w, base_w;
  logic [W-1:0]       base_r, x_r, y_r, pm_r, zm_r, r_r, r2_r;
  logic [FIELD_W-1:0] e_r;
  logic [W:0]         acc_r, acc_nxt;
  logic [W:0]         m_ext1, red_in, red_out;
  logic [W+1:0]       sum;
  logic [W-1:0]       yv, mv, x_sel, y_sel;
  logic               xi, q;

  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] res_r, res_nxt;
  status_t            status_r, status_nxt;

  // low W bits of the 32-bit fields
  assign mod_ext  = EXT_W'(mod_r);
  assign base_ext = EXT_W'(in_base);
  assign m_w      = mod_ext[W-1:0];
  assign base_w   = base_ext[W-1:0];
  assign m_ext1   = {1'b0, m_w};

  // shared conditional subtract: doubling and product finish
  assign red_in  = cmd.double_step ? {acc_r[W-1:0], 1'b0} : acc_r;
  assign red_out = (red_in >= m_ext1) ? (red_in - m_ext1) : red_in;

  // one radix-2 Montgomery iteration
  assign xi  = x_r[0];
  assign yv  = xi ? y_r : '0;
  assign q   = acc_r[0] ^ (xi & y_r[0]);
  assign mv  = q ? m_w : '0;
  assign sum = {1'b0, acc_r} + {2'b00, yv} + {2'b00, mv};

  always_comb begin
    case (cmd.mul_op)
      MUL_TO_MONT: begin x_sel = base_r; y_sel = r2_r; end
      MUL_Z:       begin x_sel = zm_r;   y_sel = pm_r; end
      MUL_SQ:      begin x_sel = pm_r;   y_sel = pm_r; end
      default:     begin x_sel = zm_r;   y_sel = W'(1); end
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.cache_init) begin
      acc_nxt = (m_w == W'(1)) ? '0 : (W+1)'(1);
    end else if (cmd.mul_start) begin
      acc_nxt = '0;
    end else if (cmd.mul_step) begin
      acc_nxt = sum[W+1:1];
    end else if (cmd.double_step) begin
      acc_nxt = red_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MODULUS_RST;
    end else if (cfg_wr) begin
      mod_r <= cfg_modulus;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.mul_start) begin
      x_r <= x_sel;
      y_r <= y_sel;
    end else if (cmd.mul_step) begin
      x_r <= x_r >> 1;
    end
    if (cmd.clear_cache) begin
      r_r  <= '0;
      r2_r <= '0;
    end
    if (cmd.save_r)  r_r  <= acc_r[W-1:0];
    if (cmd.save_r2) r2_r <= acc_r[W-1:0];
    if (cmd.load_item) begin
      base_r <= base_w;
      e_r    <= in_exponent;
      zm_r   <= r_r;               // Montgomery form of 1
    end else if (cmd.mul_finish &&
                 (cmd.mul_op == MUL_Z || cmd.mul_op == MUL_FROM_MONT)) begin
      zm_r <= red_out[W-1:0];
    end
    if (cmd.mul_finish && (cmd.mul_op == MUL_TO_MONT || cmd.mul_op == MUL_SQ)) begin
      pm_r <= red_out[W-1:0];
    end
    if (cmd.shift_e) e_r <= e_r >> 1;
  end

  // output register: freed by a transfer, reloaded by the controller
  assign zm_ext = EXT_W'(zm_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      status_nxt    = cmd.out_status;
      res_nxt       = (cmd.out_status == ST_OK) ? zm_ext[FIELD_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    res_r    <= res_nxt;
    status_r <= status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_power_result = res_r;
  assign out_status       = status_r;

  assign stat.m_even    = ~m_w[0];
  assign stat.base_ge_m = (base_r >= m_w);
  assign stat.e_zero    = (e_r == '0);
  assign stat.e_lsb     = e_r[0];
  assign stat.out_busy  = out_valid_r && !out_ready;

endmodule

FILE: rtl/mme_ctrl.sv
// ----------------------------------------------------------------------------
// mme_ctrl
// Sequencer: cache derivation, square-and-multiply loop, result hand-off.
// ----------------------------------------------------------------------------
module mme_ctrl import mme_pkg::*; #(
  parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     cfg_wr,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int unsigned CNT_W = $clog2(OPERAND_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_BITS - 1);

  ctl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  mul_op_t          op_r, op_nxt;
  status_t          code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CACHE_INIT;
      cnt_r   <= '0;
      op_r    <= MUL_TO_MONT;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.mul_op     = op_r;
    cmd.out_status = code_r;
    in_ready  = 1'b0;

    case (state_r)
      S_CACHE_INIT: begin
        if (stat.m_even) begin
          cmd.clear_cache = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.cache_init = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = S_CACHE_R;
        end
      end
      S_CACHE_R, S_CACHE_R2: begin
        cmd.double_step = 1'b1;
        cnt_nxt         = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == S_CACHE_R) ? S_SAVE_R : S_SAVE_R2;
        end
      end
      S_SAVE_R: begin
        cmd.save_r = 1'b1;
        state_nxt  = S_CACHE_R2;
      end
      S_SAVE_R2: begin
        cmd.save_r2 = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.m_even) begin
          code_nxt  = ST_MOD_EVEN;
          state_nxt = S_OUT;
        end else if (stat.base_ge_m) begin
          code_nxt  = ST_BASE_RANGE;
          state_nxt = S_OUT;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_TO_MONT;
          op_nxt        = MUL_TO_MONT;
          cnt_nxt       = '0;
          state_nxt     = S_MUL;
        end
      end
      S_EXP: begin
        cmd.mul_start = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_MUL;
        if (stat.e_zero) begin
          op_nxt = MUL_FROM_MONT;
        end else if (stat.e_lsb) begin
          op_nxt = MUL_Z;
        end else begin
          op_nxt = MUL_SQ;
        end
        cmd.mul_op = op_nxt;
      end
      S_SQ: begin
        cmd.mul_start = 1'b1;
        cmd.mul_op    = MUL_SQ;
        op_nxt        = MUL_SQ;
        cnt_nxt       = '0;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL_FIN;
        end
      end
      S_MUL_FIN: begin
        cmd.mul_finish = 1'b1;
        case (op_r)
          MUL_TO_MONT: state_nxt = S_EXP;
          MUL_Z:       state_nxt = S_SQ;
          MUL_SQ: begin
            cmd.shift_e = 1'b1;
            state_nxt   = S_EXP;
          end
          default: begin
            code_nxt  = ST_OK;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CACHE_INIT;
    endcase

    // a modulus write restarts the cache derivation
    if (cfg_wr) begin
      state_nxt     = S_CACHE_INIT;
      in_ready      = 1'b0;
      cmd.load_item = 1'b0;
    end
  end

endmodule

FILE: rtl/mme_checker.sv
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks for the Montgomery exponentiation block.
// ----------------------------------------------------------------------------
`include "montgomery_modular_exponentiation_top_assert.svh"

module mme_checker import mme_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [FIELD_W-1:0]  out_power_result,
  input logic [STATUS_W-1:0] out_status,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  // stalled result holds
  `MME_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_power_result) && $stable(out_status), "stalled result changed")

  `MME_ASSERT(a_status_code, clk, rst_n, out_valid |-> (out_status == ST_OK || out_status == ST_BASE_RANGE || out_status == ST_MOD_EVEN), "unknown status code")

  `MME_ASSERT(a_err_zero, clk, rst_n, out_valid && out_status != ST_OK |-> out_power_result == '0, "error result not zero")

  // cache derivation follows reset and every modulus write
  `MME_ASSERT_ALWAYS(a_rst_busy, clk, !rst_n |=> !in_ready, "input taken right after reset")

  `MME_ASSERT(a_cfg_busy, clk, rst_n, cfg_valid && cfg_ready |=> !in_ready, "input taken right after modulus write")

endmodule

bind montgomery_modular_exponentiation_top mme_checker u_mme_checker (.*);
